>>> sv/qoi_pkg.sv
`default_nettype none
package qoi_pkg;

    localparam int QW   = 32;   // Q2.30 quaternion component
    localparam int RW   = 32;   // Q8.24 rate
    localparam int DTW  = 24;   // Q0.24 time step
    localparam int AW   = 44;   // parallel multiplicand
    localparam int ACW  = 45;   // high half of the serial product
    localparam int SW   = 46;   // sum before clipping
    localparam int PW   = ACW + QW;

    localparam int N_OPS      = 16;
    localparam int N_RATE_OPS = 12;
    localparam int RATE_SHIFT = 24;
    localparam int DT_SHIFT   = 25;

    localparam logic [QW-1:0]  Q_ONE    = 32'h4000_0000;
    localparam logic [DTW-1:0] DT_RESET = 24'd167772;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic [1:0] rsel;   // rate component
        logic [1:0] qsel;   // quaternion component (w x y z)
        logic [1:0] psel;   // target of the hamilton product
        logic       neg;    // subtract the term
    } t_op;

    // p = (0,v)*q, one rate*component term per op
    function automatic t_op op_decode(input logic [3:0] k);
        t_op o;
        o = '0;
        unique case (k)
            4'd0:  o = '{2'd0, 2'd1, 2'd0, 1'b1};
            4'd1:  o = '{2'd1, 2'd2, 2'd0, 1'b1};
            4'd2:  o = '{2'd2, 2'd3, 2'd0, 1'b1};
            4'd3:  o = '{2'd0, 2'd0, 2'd1, 1'b0};
            4'd4:  o = '{2'd1, 2'd3, 2'd1, 1'b0};
            4'd5:  o = '{2'd2, 2'd2, 2'd1, 1'b1};
            4'd6:  o = '{2'd1, 2'd0, 2'd2, 1'b0};
            4'd7:  o = '{2'd2, 2'd1, 2'd2, 1'b0};
            4'd8:  o = '{2'd0, 2'd3, 2'd2, 1'b1};
            4'd9:  o = '{2'd2, 2'd0, 2'd3, 1'b0};
            4'd10: o = '{2'd0, 2'd2, 2'd3, 1'b0};
            4'd11: o = '{2'd1, 2'd1, 2'd3, 1'b1};
            default: o = '0;
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

>>> sv/qoi_if.sv
`default_nettype none
interface qoi_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] load_w;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
    modport source (output valid, cmd, rate_x, rate_y, rate_z,
                    load_w, load_x, load_y, load_z, input ready);
    modport sink (input valid, cmd, rate_x, rate_y, rate_z,
                  load_w, load_x, load_y, load_z, output ready);
endinterface

interface qoi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               saturated;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, saturated,
                    input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, saturated,
                  output ready);
endinterface
`default_nettype wire

>>> sv/quaternion_orientation_integrator.sv
// load beat: the orientation is loaded and passes through S_OUT into the output register
// step beat: 16 serial products, each through S_LOAD, S_MUL and S_ACC, then S_OUT
// throughput: one beat at a time, next accept in the same cycle as the result goes valid,
// later while the output register is stalled
// reset: orientation goes to identity (1,0,0,0), time step to about 0.01 s,
// no result pending
`default_nettype none
module quaternion_orientation_integrator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_wr_en,
    input  wire logic [qoi_pkg::DTW-1:0] i_cfg_wr_data,
    qoi_in_if.sink     i_in,
    qoi_out_if.source  o_out
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_ACC, S_OUT} t_state;

    t_state r_state;

    // orientation w x y z and the hamilton product accumulators
    logic signed [qoi_pkg::QW-1:0]  r_q [4];
    logic signed [qoi_pkg::AW-1:0]  r_p [4];
    logic signed [qoi_pkg::RW-1:0]  r_rate [3];
    logic [qoi_pkg::DTW-1:0]        r_dt;

    // serial multiplier: parallel multiplicand, multiplier shifts out lsb first
    logic signed [qoi_pkg::AW-1:0]  r_a;
    logic signed [qoi_pkg::ACW-1:0] r_acc;
    logic [qoi_pkg::QW-1:0]         r_low;
    logic [4:0]                     r_bit;
    logic [3:0]                     r_op;
    logic                           r_sat;

    logic                           r_out_valid;
    logic signed [qoi_pkg::QW-1:0]  r_out_q [4];
    logic                           r_out_sat;

    qoi_pkg::t_op                   w_op;
    logic signed [qoi_pkg::ACW-1:0] w_addend;
    logic signed [qoi_pkg::ACW-1:0] w_sum;
    logic signed [qoi_pkg::PW-1:0]  w_prod;
    logic signed [qoi_pkg::AW-1:0]  w_term;
    logic signed [qoi_pkg::SW-1:0]  w_inc;
    logic signed [qoi_pkg::SW-1:0]  w_s;
    logic                           w_rate_phase;

    assign w_op         = qoi_pkg::op_decode(r_op);
    assign w_rate_phase = (r_op < 4'(qoi_pkg::N_RATE_OPS));

    // the multiplier's last bit carries negative weight (two's complement)
    assign w_addend = r_low[0] ? qoi_pkg::ACW'(r_a) : '0;
    assign w_sum    = (r_bit == 5'd31) ? r_acc - w_addend : r_acc + w_addend;

    // arithmetic shifts of the exact product round toward minus infinity
    assign w_prod = {r_acc, r_low};
    assign w_term = w_prod[qoi_pkg::RATE_SHIFT +: qoi_pkg::AW];
    assign w_inc  = w_prod[qoi_pkg::DT_SHIFT +: qoi_pkg::SW];
    assign w_s    = qoi_pkg::SW'(r_q[r_op[1:0]]) + w_inc;

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.quat_w    = r_out_q[0];
    assign o_out.quat_x    = r_out_q[1];
    assign o_out.quat_y    = r_out_q[2];
    assign o_out.quat_z    = r_out_q[3];
    assign o_out.saturated = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q[0]      <= qoi_pkg::Q_ONE;
            r_q[1]      <= '0;
            r_q[2]      <= '0;
            r_q[3]      <= '0;
            r_dt        <= qoi_pkg::DT_RESET;
            r_out_valid <= 1'b0;
            r_op        <= '0;
            r_bit       <= '0;
            r_sat       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dt <= i_cfg_wr_data;
            end
            // the output state refills the register itself
            if (o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_sat <= 1'b0;
                        if (i_in.cmd == qoi_pkg::CMD_LOAD) begin
                            r_q[0]  <= i_in.load_w;
                            r_q[1]  <= i_in.load_x;
                            r_q[2]  <= i_in.load_y;
                            r_q[3]  <= i_in.load_z;
                            r_state <= S_OUT;
                        end else begin
                            r_rate[0] <= i_in.rate_x;
                            r_rate[1] <= i_in.rate_y;
                            r_rate[2] <= i_in.rate_z;
                            for (int i = 0; i < 4; i++) begin
                                r_p[i] <= '0;
                            end
                            r_op    <= '0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    // rate terms use the rate as multiplicand, dt terms use p
                    if (w_rate_phase) begin
                        r_a   <= qoi_pkg::AW'(r_rate[w_op.rsel]);
                        r_low <= r_q[w_op.qsel];
                    end else begin
                        r_a   <= r_p[r_op[1:0]];
                        r_low <= qoi_pkg::QW'(r_dt);
                    end
                    r_acc   <= '0;
                    r_bit   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= w_sum >>> 1;
                    r_low <= {w_sum[0], r_low[qoi_pkg::QW-1:1]};
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd31) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (w_rate_phase) begin
                        if (w_op.neg) begin
                            r_p[w_op.psel] <= r_p[w_op.psel] - w_term;
                        end else begin
                            r_p[w_op.psel] <= r_p[w_op.psel] + w_term;
                        end
                    end else begin
                        // clip to the q2.30 range
                        if (w_s > qoi_pkg::SW'(32'sh7fff_ffff)) begin
                            r_q[r_op[1:0]] <= 32'sh7fff_ffff;
                            r_sat          <= 1'b1;
                        end else if (w_s < -(qoi_pkg::SW'(33'sh0_8000_0000))) begin
                            r_q[r_op[1:0]] <= 32'sh8000_0000;
                            r_sat          <= 1'b1;
                        end else begin
                            r_q[r_op[1:0]] <= w_s[qoi_pkg::QW-1:0];
                        end
                    end
                    if (r_op == 4'(qoi_pkg::N_OPS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    // wait for the output register to free up
                    if (!r_out_valid || o_out.ready) begin
                        for (int i = 0; i < 4; i++) begin
                            r_out_q[i] <= r_q[i];
                        end
                        r_out_sat   <= r_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> test/tb_quaternion_orientation_integrator.sv
`default_nettype none
module tb_quaternion_orientation_integrator;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [qoi_pkg::DTW-1:0] i_cfg_wr_data;

    qoi_in_if  in_ch ();
    qoi_out_if out_ch ();

    quaternion_orientation_integrator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch.sink),
        .o_out         (out_ch.source)
    );

    // expected orientation beat
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_quat_beat;

    // predictor state: orientation (w x y z) and time step
    logic signed [63:0]      attitude [4];
    logic [qoi_pkg::DTW-1:0] step_dt;

    t_quat_beat pending_quats [$];
    int  err_count = 0;
    int  beats_sent;
    int  beats_checked = 0;
    int  sat_seen = 0;
    int  idle_cycles = 0;
    bit  quiet_mode;   // last part of the run: no bubbles on either side

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // floor of a signed value divided by 2^k; >>> on signed already floors
    function automatic logic signed [63:0] floor_div(input logic signed [63:0] v,
                                                     input int k);
        return v >>> k;
    endfunction

    // rate (Q8.24) times component (Q2.30), down to Q10.30
    function automatic logic signed [63:0] rate_term(input logic signed [63:0] r,
                                                     input logic signed [63:0] c);
        return floor_div(r * c, qoi_pkg::RATE_SHIFT);
    endfunction

    // p*dt/2 with flooring; |p| < 2^42 so the product fits in 96 bits
    function automatic logic signed [63:0] dt_increment(input logic signed [63:0] p,
                                                        input logic [qoi_pkg::DTW-1:0] dt);
        logic signed [95:0] prod;
        prod = $signed({{32{p[63]}}, p}) * $signed({72'd0, dt});
        prod = prod >>> qoi_pkg::DT_SHIFT;
        return prod[63:0];
    endfunction

    // one input beat into the predictor, result onto the queue
    task automatic predict_attitude(input logic cmd, input logic signed [31:0] vx,
                                    input logic signed [31:0] vy,
                                    input logic signed [31:0] vz,
                                    input logic signed [31:0] lw,
                                    input logic signed [31:0] lx,
                                    input logic signed [31:0] ly,
                                    input logic signed [31:0] lz);
        logic signed [63:0] p [4];
        logic signed [63:0] s;
        logic clipped;
        t_quat_beat e;
        clipped = 1'b0;
        if (cmd == qoi_pkg::CMD_LOAD) begin
            attitude[0] = lw;
            attitude[1] = lx;
            attitude[2] = ly;
            attitude[3] = lz;
        end else begin
            // hamilton product (0,v)*q
            p[0] = -(rate_term(vx, attitude[1]) + rate_term(vy, attitude[2])
                     + rate_term(vz, attitude[3]));
            p[1] = rate_term(vx, attitude[0]) + rate_term(vy, attitude[3])
                   - rate_term(vz, attitude[2]);
            p[2] = rate_term(vy, attitude[0]) + rate_term(vz, attitude[1])
                   - rate_term(vx, attitude[3]);
            p[3] = rate_term(vz, attitude[0]) + rate_term(vx, attitude[2])
                   - rate_term(vy, attitude[1]);
            for (int i = 0; i < 4; i++) begin
                s = attitude[i] + dt_increment(p[i], step_dt);
                if (s > 64'sd2147483647) begin
                    s = 64'sd2147483647;
                    clipped = 1'b1;
                end else if (s < -64'sd2147483648) begin
                    s = -64'sd2147483648;
                    clipped = 1'b1;
                end
                attitude[i] = s;
            end
        end
        e.w = attitude[0][31:0];
        e.x = attitude[1][31:0];
        e.y = attitude[2][31:0];
        e.z = attitude[3][31:0];
        e.sat = clipped;
        pending_quats.push_back(e);
    endtask

    // random bubble on the input side, none in the quiet part
    task automatic maybe_bubble();
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // drive one beat and hold it until accepted; valid stays up for the next beat
    task automatic send_beat(input logic cmd, input logic signed [31:0] vx,
                             input logic signed [31:0] vy,
                             input logic signed [31:0] vz,
                             input logic signed [31:0] lw,
                             input logic signed [31:0] lx,
                             input logic signed [31:0] ly,
                             input logic signed [31:0] lz);
        maybe_bubble();
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= cmd;
        in_ch.rate_x <= vx;
        in_ch.rate_y <= vy;
        in_ch.rate_z <= vz;
        in_ch.load_w <= lw;
        in_ch.load_x <= lx;
        in_ch.load_y <= ly;
        in_ch.load_z <= lz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_attitude(cmd, vx, vy, vz, lw, lx, ly, lz);
        beats_sent++;
    endtask

    task automatic send_step(input logic signed [31:0] vx,
                             input logic signed [31:0] vy,
                             input logic signed [31:0] vz);
        send_beat(qoi_pkg::CMD_STEP, vx, vy, vz, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_load(input logic signed [31:0] lw,
                             input logic signed [31:0] lx,
                             input logic signed [31:0] ly,
                             input logic signed [31:0] lz);
        send_beat(qoi_pkg::CMD_LOAD, $urandom, $urandom, $urandom, lw, lx, ly, lz);
    endtask

    // wait for all results, then write the time step while idle
    task automatic set_time_step(input logic [qoi_pkg::DTW-1:0] dt);
        in_ch.valid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= dt;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        step_dt = dt;
    endtask

    // rate with a spread of magnitudes so both gentle and violent spins occur
    function automatic logic signed [31:0] rand_rate();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_comp();
        if ($urandom_range(0, 2) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
    endfunction

    // extremes of the rate and load fields, identity start, clipping
    task automatic test_directed_extremes();
        send_step(32'sd0, 32'sd0, 32'sd0);                  // identity, no rate
        send_step(32'sh0100_0000, 32'sd0, 32'sd0);          // 1 rad/s about x
        send_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_step(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_load(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_step(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);   // clips
        send_load(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_step(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_load(32'sh4000_0000, 32'sd0, 32'sd0, 32'sd0);
        send_step(-32'sd1, -32'sd1, -32'sd1);               // floor on tiny negatives
        send_load(-32'sd1, 32'sd1, -32'sd1, 32'sd1);
        send_step(32'sd1, -32'sd1, 32'sd1);
        send_load(32'sh2D41_3CCD, 32'sh2D41_3CCD, 32'sd0, 32'sd0);
        send_step(32'sh0000_0000, 32'sh0300_0000, -32'sh0200_0000);
    endtask

    // extremes of the time step register
    task automatic test_time_step_extremes();
        set_time_step('0);                                  // zero step holds q
        send_load(32'sh1234_5678, -32'sh1234_5678, 32'sh0ABC_DEF0, 32'sd5);
        send_step(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
        set_time_step({qoi_pkg::DTW{1'b1}});                // largest step
        send_step(32'sh0100_0000, 32'sh0200_0000, -32'sh0300_0000);
        send_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        set_time_step(24'd1);
        send_step(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        set_time_step(qoi_pkg::DT_RESET);
    endtask

    // integration runs with an occasional reload, several step settings
    task automatic test_random_integration(input int n_beats);
        for (int i = 0; i < n_beats; i++) begin
            if (i % 100 == 99)
                set_time_step(qoi_pkg::DTW'($urandom_range(0, 3) == 0 ?
                                            $urandom : $urandom_range(0, 24'h04_0000)));
            if ($urandom_range(0, 9) == 0)
                send_load(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            else
                send_step(rand_rate(), rand_rate(), rand_rate());
        end
    endtask

    // result side: random stalls and the check against the oldest expectation
    always @(posedge i_clk) begin
        t_quat_beat e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_quats.size() == 0) begin
                    $display("%0t: result beat with nothing expected: w=%h x=%h y=%h z=%h",
                             $realtime, out_ch.quat_w, out_ch.quat_x,
                             out_ch.quat_y, out_ch.quat_z);
                    err_count++;
                end else begin
                    e = pending_quats.pop_front();
                    beats_checked++;
                    if (out_ch.saturated) sat_seen++;
                    if (out_ch.quat_w !== e.w || out_ch.quat_x !== e.x ||
                        out_ch.quat_y !== e.y || out_ch.quat_z !== e.z ||
                        out_ch.saturated !== e.sat) begin
                        $display("%0t: mismatch exp w=%h x=%h y=%h z=%h sat=%b",
                                 $realtime, e.w, e.x, e.y, e.z, e.sat);
                        $display("%0t:          got w=%h x=%h y=%h z=%h sat=%b",
                                 $realtime, out_ch.quat_w, out_ch.quat_x,
                                 out_ch.quat_y, out_ch.quat_z, out_ch.saturated);
                        err_count++;
                    end
                end
            end
            // random stalls on the result side; none in the quiet part
            if (quiet_mode) begin
                out_ch.ready <= 1'b1;
            end else if (!out_ch.ready) begin
                out_ch.ready <= ($urandom_range(0, 2) != 0);
            end else begin
                out_ch.ready <= ($urandom_range(0, 4) != 0);
            end
        end
    end

    // watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("watchdog: no progress, %0d beats still outstanding",
                     pending_quats.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int drain;
        beats_sent    = 0;
        quiet_mode    = 1'b0;
        attitude[0]   = qoi_pkg::Q_ONE;
        attitude[1]   = 0;
        attitude[2]   = 0;
        attitude[3]   = 0;
        step_dt       = qoi_pkg::DT_RESET;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = qoi_pkg::CMD_STEP;
        in_ch.rate_x  = '0;
        in_ch.rate_y  = '0;
        in_ch.rate_z  = '0;
        in_ch.load_w  = '0;
        in_ch.load_x  = '0;
        in_ch.load_y  = '0;
        in_ch.load_z  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_time_step_extremes();
        test_random_integration(330);
        quiet_mode = 1'b1;
        test_random_integration(50);
        in_ch.valid <= 1'b0;

        // drain, then allow for any late stray beat
        while (pending_quats.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 600) begin
            @(posedge i_clk);
            drain++;
        end

        $display("covered %0d beats (%0d checked, %0d clipped) over several time steps",
                 beats_sent, beats_checked, sat_seen);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
